FILE: hdl/bdpc_pkg.sv
// shared types and codes of the button debounce and press classifier
package bdpc_pkg;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  // event kind codes
  typedef enum logic [1:0] {
    KIND_PRESS = 2'd0,
    KIND_SHORT = 2'd1,
    KIND_LONG  = 2'd2
  } kind_e;

  // configuration register indexes
  localparam logic [1:0] REG_ENABLE_MASK    = 2'd0;
  localparam logic [1:0] REG_SETTLE_TICKS   = 2'd1;
  localparam logic [1:0] REG_LONG_THRESHOLD = 2'd2;

  // register reset values
  localparam logic [31:0] ENABLE_RESET    = 32'h0000_0000;
  localparam logic [15:0] SETTLE_RESET    = 16'd5;
  localparam logic [15:0] THRESHOLD_RESET = 16'd1000;

endpackage

FILE: hdl/button_debounce_press_classifier_unit.sv
// Button debounce and press classifier: takes one pin-level word per 1 ms tick, walks the
// pins one per cycle through a shared subtractor, stalling while an event waits on an output
// word not yet taken, and emits debounced press and release events in ascending pin order,
// the final event of a tick flagged by last_event_o. A tick runs through accept, the serial
// pin walk and a flush state. pin_ready_o is high only between ticks. Configuration writes
// are taken at any cycle and are meant to happen while the block is idle.
module button_debounce_press_classifier_unit #(
  parameter int NUM_PINS   = 32,
  parameter int TIME_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // tick input channel
  input  logic        pin_valid_i,
  output logic        pin_ready_o,
  input  logic [31:0] pin_levels_i,
  // event output channel
  output logic        evt_valid_o,
  input  logic        evt_ready_i,
  output logic [4:0]  pin_index_o,
  output logic        stable_level_o,
  output logic [1:0]  press_kind_o,
  output logic [15:0] event_time_o,
  output logic        last_event_o
);

  localparam int PW = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;
  localparam int UW = (TIME_WIDTH > 16) ? TIME_WIDTH : 16;
  localparam logic [PW-1:0] LAST_PIN = PW'(NUM_PINS - 1);

  // configuration registers
  logic [31:0] enable_q;
  logic [15:0] settle_q;
  logic [15:0] thresh_q;

  // per-pin and tick state
  bdpc_pkg::state_e state_q, state_d;
  logic [PW-1:0]         pin_q;
  logic [NUM_PINS-1:0]   levels_q;
  logic [NUM_PINS-1:0]   prev_q;
  logic [NUM_PINS-1:0]   prev2_q;
  logic [NUM_PINS-1:0]   act_q;
  logic [15:0]           cnt_q [NUM_PINS];
  logic [TIME_WIDTH-1:0] down_q [NUM_PINS];
  logic [TIME_WIDTH-1:0] time_q;

  // pending event, held until the next event or the end of the tick
  logic                  pend_valid_q;
  logic [4:0]            pend_pin_q;
  logic                  pend_level_q;
  bdpc_pkg::kind_e       pend_kind_q;

  // output word register
  logic                  out_valid_q;
  logic [4:0]            out_pin_q;
  logic                  out_level_q;
  bdpc_pkg::kind_e       out_kind_q;
  logic [15:0]           out_time_q;
  logic                  out_last_q;

  // current pin view
  logic [NUM_PINS-1:0] en_vec;
  logic                en, cur, p1, p2, act, cnt_small;
  logic [15:0]         cnt_cur;
  logic [TIME_WIDTH-1:0] down_cur;

  // shared subtractor
  logic [UW-1:0] sub_a, sub_b, sub_y;
  logic          sub_c;
  logic          is_long;

  // control
  logic    out_free;
  logic    ev;
  logic    step;
  logic    push_pend;
  logic    flush_push;
  logic    tick_done;
  logic [UW-1:0] time_ext;

  assign en_vec    = enable_q[NUM_PINS-1:0];
  assign en        = en_vec[pin_q];
  assign cur       = levels_q[pin_q];
  assign p1        = prev_q[pin_q];
  assign p2        = prev2_q[pin_q];
  assign act       = act_q[pin_q];
  assign cnt_cur   = cnt_q[pin_q];
  assign down_cur  = down_q[pin_q];
  assign cnt_small = (cnt_cur <= 16'd1);
  assign time_ext  = UW'(time_q);

  // shared unit: count decrement or held time, a - b - c
  always_comb begin
    if (cur != p1 || cnt_small == 1'b0) begin
      sub_a = UW'(cnt_cur);
      sub_b = UW'(1);
      sub_c = 1'b0;
    end else begin
      sub_a = time_ext;
      sub_b = UW'(down_cur);
      sub_c = (time_q < down_cur);
    end
  end
  assign sub_y   = sub_a - sub_b - UW'(sub_c);
  // held time wraps at the timestamp width
  assign is_long = (UW'(sub_y[TIME_WIDTH-1:0]) >= UW'(thresh_q));

  // event detect for the pin under the walk
  assign ev = en && (cur == p1) && act && cnt_small && (cur == p2);

  assign out_free   = !out_valid_q || evt_ready_i;
  assign step       = (state_q == bdpc_pkg::ST_SCAN) && !(ev && pend_valid_q && !out_free);
  assign push_pend  = step && ev && pend_valid_q;
  assign flush_push = (state_q == bdpc_pkg::ST_FLUSH) && pend_valid_q && out_free;
  assign tick_done  = (state_q == bdpc_pkg::ST_FLUSH) && (!pend_valid_q || out_free);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bdpc_pkg::ST_IDLE: begin
        if (pin_valid_i) state_d = bdpc_pkg::ST_SCAN;
      end
      bdpc_pkg::ST_SCAN: begin
        if (step && pin_q == LAST_PIN) state_d = bdpc_pkg::ST_FLUSH;
      end
      bdpc_pkg::ST_FLUSH: begin
        if (tick_done) state_d = bdpc_pkg::ST_IDLE;
      end
      default: state_d = bdpc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bdpc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= bdpc_pkg::ENABLE_RESET;
      settle_q <= bdpc_pkg::SETTLE_RESET;
      thresh_q <= bdpc_pkg::THRESHOLD_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bdpc_pkg::REG_ENABLE_MASK:    enable_q <= cfg_data_i;
        bdpc_pkg::REG_SETTLE_TICKS:   settle_q <= cfg_data_i[15:0];
        bdpc_pkg::REG_LONG_THRESHOLD: thresh_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // tick capture, pin walk counter, timestamp and level history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_q   <= '0;
      prev_q  <= '1;
      prev2_q <= '1;
      time_q  <= '0;
    end else begin
      if (state_q == bdpc_pkg::ST_IDLE && pin_valid_i) begin
        pin_q <= '0;
      end else if (step && pin_q != LAST_PIN) begin
        pin_q <= pin_q + PW'(1);
      end
      if (tick_done) begin
        time_q  <= time_q + TIME_WIDTH'(1);
        prev2_q <= prev_q;
        prev_q  <= levels_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == bdpc_pkg::ST_IDLE && pin_valid_i) begin
      levels_q <= pin_levels_i[NUM_PINS-1:0];
    end
  end

  // per-pin settle countdown and down time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= '0;
      for (int i = 0; i < NUM_PINS; i++) begin
        cnt_q[i]  <= '0;
        down_q[i] <= '0;
      end
    end else if (step) begin
      if (!en) begin
        act_q[pin_q] <= 1'b0;
      end else if (cur != p1) begin
        act_q[pin_q] <= 1'b1;
        cnt_q[pin_q] <= settle_q;
      end else if (act) begin
        if (!cnt_small) begin
          cnt_q[pin_q] <= sub_y[15:0];
        end else if (cur != p2) begin
          cnt_q[pin_q] <= settle_q;
        end else begin
          act_q[pin_q] <= 1'b0;
          if (!cur) down_q[pin_q] <= time_q;
        end
      end
    end
  end

  // pending event valid and output word valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (step && ev) begin
        pend_valid_q <= 1'b1;
      end else if (flush_push) begin
        pend_valid_q <= 1'b0;
      end
      if (push_pend || flush_push) begin
        out_valid_q <= 1'b1;
      end else if (evt_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // event payloads
  always_ff @(posedge clk_i) begin
    if (step && ev) begin
      pend_pin_q   <= 5'(pin_q);
      pend_level_q <= cur;
      if (!cur) begin
        pend_kind_q <= bdpc_pkg::KIND_PRESS;
      end else if (is_long) begin
        pend_kind_q <= bdpc_pkg::KIND_LONG;
      end else begin
        pend_kind_q <= bdpc_pkg::KIND_SHORT;
      end
    end
    if (push_pend || flush_push) begin
      out_pin_q   <= pend_pin_q;
      out_level_q <= pend_level_q;
      out_kind_q  <= pend_kind_q;
      out_time_q  <= time_ext[15:0];
      out_last_q  <= flush_push;
    end
  end

  assign cfg_ready_o    = 1'b1;
  assign pin_ready_o    = (state_q == bdpc_pkg::ST_IDLE);
  assign evt_valid_o    = out_valid_q;
  assign pin_index_o    = out_pin_q;
  assign stable_level_o = out_level_q;
  assign press_kind_o   = out_kind_q;
  assign event_time_o   = out_time_q;
  assign last_event_o   = out_last_q;

endmodule

FILE: hdl/bdpc_checker.sv
// port-level checker of the button debounce and press classifier, with its bind
module bdpc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        pin_valid_i,
  input logic        pin_ready_o,
  input logic        evt_valid_o,
  input logic        evt_ready_i,
  input logic [4:0]  pin_index_o,
  input logic        stable_level_o,
  input logic [1:0]  press_kind_o,
  input logic [15:0] event_time_o,
  input logic        last_event_o
);

  // a stalled output word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_o && !evt_ready_i |=> evt_valid_o && $stable(pin_index_o) &&
      $stable(press_kind_o) && $stable(event_time_o) && $stable(last_event_o))
    else $error("stalled event word changed");

  // a pressed level goes with a press code, a released level with a release code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_o |-> ((stable_level_o == 1'b0) == (press_kind_o == bdpc_pkg::KIND_PRESS)))
    else $error("level and kind disagree");

  // no undefined kind code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_o |-> (press_kind_o == bdpc_pkg::KIND_PRESS ||
      press_kind_o == bdpc_pkg::KIND_SHORT || press_kind_o == bdpc_pkg::KIND_LONG))
    else $error("undefined kind code");

  // ready drops right after a tick is accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pin_valid_i && pin_ready_o |=> !pin_ready_o)
    else $error("ready right after a tick");

endmodule

bind button_debounce_press_classifier_unit bdpc_checker u_bdpc_checker (.*);

FILE: tb/sv/tb.sv
// testbench for the button debounce and press classifier: drives pin ticks, predicts events
`timescale 1ns / 1ps

module tb;

  // index that maps to no register, writes to it must be ignored
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int N_PINS = 32;
  localparam int DRAIN_CYCLES = N_PINS + 8;
  localparam int STALL_LIMIT = 4000;

  typedef struct {
    logic [4:0]        pin;
    logic              level;
    bdpc_pkg::kind_e   kind;
    logic [15:0]       stamp;
    logic              last;
  } press_evt_t;

  // tracks debounce state per pin and holds the events still owed by the block
  class debounce_scoreboard;
    logic [31:0] en_mask;
    logic [15:0] settle_len;
    logic [15:0] long_limit;
    logic [31:0] lv_prev;
    logic [31:0] lv_prev2;
    logic [31:0] counting;
    logic [15:0] remaining [N_PINS];
    logic [15:0] press_stamp [N_PINS];
    logic [15:0] tick_now;
    press_evt_t  owed_events [$];
    int          failures;

    function new();
      en_mask    = bdpc_pkg::ENABLE_RESET;
      settle_len = bdpc_pkg::SETTLE_RESET;
      long_limit = bdpc_pkg::THRESHOLD_RESET;
      lv_prev    = '1;
      lv_prev2   = '1;
      counting   = '0;
      tick_now   = '0;
      failures   = 0;
      for (int p = 0; p < N_PINS; p++) begin
        remaining[p]   = '0;
        press_stamp[p] = '0;
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        bdpc_pkg::REG_ENABLE_MASK:    en_mask = data;
        bdpc_pkg::REG_SETTLE_TICKS:   settle_len = data[15:0];
        bdpc_pkg::REG_LONG_THRESHOLD: long_limit = data[15:0];
        default: ;
      endcase
    endfunction

    // walk all pins for one tick and queue the events it should produce
    function void note_tick(logic [31:0] levels);
      press_evt_t ev;
      logic       cur;
      logic [15:0] held;
      int         owed_before;
      owed_before = owed_events.size();
      for (int p = 0; p < N_PINS; p++) begin
        cur = levels[p];
        if (!en_mask[p]) begin
          counting[p] = 1'b0;
          continue;
        end
        // any edge restarts the countdown
        if (cur != lv_prev[p]) begin
          counting[p]  = 1'b1;
          remaining[p] = settle_len;
          continue;
        end
        if (!counting[p]) continue;
        if (remaining[p] > 16'd1) begin
          remaining[p] = remaining[p] - 16'd1;
          continue;
        end
        // expired but the older sample disagrees
        if (cur != lv_prev2[p]) begin
          remaining[p] = settle_len;
          continue;
        end
        counting[p] = 1'b0;
        ev.pin   = 5'(p);
        ev.level = cur;
        ev.stamp = tick_now;
        ev.last  = 1'b0;
        if (!cur) begin
          press_stamp[p] = tick_now;
          ev.kind = bdpc_pkg::KIND_PRESS;
        end else begin
          // held time with the wrap rule of the original firmware
          if (tick_now >= press_stamp[p]) held = tick_now - press_stamp[p];
          else held = (16'hFFFF - press_stamp[p]) + tick_now;
          ev.kind = (held < long_limit) ? bdpc_pkg::KIND_SHORT : bdpc_pkg::KIND_LONG;
        end
        owed_events.push_back(ev);
      end
      if (owed_events.size() > owed_before) owed_events[$].last = 1'b1;
      tick_now = tick_now + 16'd1;
      lv_prev2 = lv_prev;
      lv_prev  = levels;
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= 10) $display("mismatch: %s", msg);
    endfunction

    function void check_event(logic [4:0] pin, logic level, logic [1:0] kind,
                              logic [15:0] stamp, logic last);
      press_evt_t ev;
      if (owed_events.size() == 0) begin
        flag($sformatf("unexpected event pin %0d level %0d kind %0d time %0d last %0d",
                       pin, level, kind, stamp, last));
        return;
      end
      ev = owed_events.pop_front();
      if (ev.pin != pin || ev.level != level || ev.kind != kind ||
          ev.stamp != stamp || ev.last != last)
        flag($sformatf("exp pin %0d level %0d kind %0d time %0d last %0d, got %0d %0d %0d %0d %0d",
                       ev.pin, ev.level, ev.kind, ev.stamp, ev.last,
                       pin, level, kind, stamp, last));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;
  logic        pin_valid_i;
  logic        pin_ready_o;
  logic [31:0] pin_levels_i;
  logic        evt_valid_o;
  logic        evt_ready_i;
  logic [4:0]  pin_index_o;
  logic        stable_level_o;
  logic [1:0]  press_kind_o;
  logic [15:0] event_time_o;
  logic        last_event_o;

  debounce_scoreboard sb;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          stall_cycles;
  logic [31:0] steady_lv;

  button_debounce_press_classifier_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .pin_valid_i    (pin_valid_i),
    .pin_ready_o    (pin_ready_o),
    .pin_levels_i   (pin_levels_i),
    .evt_valid_o    (evt_valid_o),
    .evt_ready_i    (evt_ready_i),
    .pin_index_o    (pin_index_o),
    .stable_level_o (stable_level_o),
    .press_kind_o   (press_kind_o),
    .event_time_o   (event_time_o),
    .last_event_o   (last_event_o)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // event receiver with random back-pressure
  always @(negedge clk_i) begin
    evt_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // compare each accepted event word
  always @(posedge clk_i) begin
    if (rst_ni && evt_valid_o && evt_ready_i)
      sb.check_event(pin_index_o, stable_level_o, press_kind_o, event_time_o, last_event_o);
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk_i) begin
    if ((pin_valid_i && pin_ready_o) || (evt_valid_o && evt_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[button_debounce_press_classifier_unit] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_tick(input logic [31:0] levels);
    while ($urandom_range(99) < send_idle_pct) begin
      pin_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    pin_valid_i  <= 1'b1;
    pin_levels_i <= levels;
    @(posedge clk_i);
    while (!pin_ready_o) @(posedge clk_i);
    sb.note_tick(levels);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic set_config(input logic [31:0] en, input logic [31:0] settle,
                            input logic [31:0] limit);
    write_reg(bdpc_pkg::REG_ENABLE_MASK, en);
    write_reg(bdpc_pkg::REG_SETTLE_TICKS, settle);
    write_reg(bdpc_pkg::REG_LONG_THRESHOLD, limit);
    cfg_valid_i <= 1'b0;
  endtask

  // stop sending and let the block drain, including ticks that raise no event
  task automatic drain();
    pin_valid_i <= 1'b0;
    while (sb.owed_events.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // mostly stable levels with real changes and one-tick bounces, some pure noise
  function automatic logic [31:0] next_levels();
    logic [31:0] w;
    int          r;
    r = $urandom_range(99);
    if (r < 10) return $urandom;
    if (r < 35) steady_lv = steady_lv ^ ($urandom & $urandom & $urandom);
    w = steady_lv;
    if ($urandom_range(99) < 20) w = w ^ ($urandom & $urandom & $urandom);
    return w;
  endfunction

  logic [31:0] directed_lv [17] = '{
    32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
    32'hFFFF_FFFF, 32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF, 32'hFFFF_FFFF,
    32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'h5555_5555, 32'h8000_0001,
    32'h8000_0001, 32'h0000_0000
  };

  initial begin
    sb             = new();
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = bdpc_pkg::REG_ENABLE_MASK;
    cfg_data_i     = '0;
    pin_valid_i    = 1'b0;
    pin_levels_i   = '0;
    send_idle_pct  = 33;
    recv_idle_pct  = 87;
    steady_lv      = '1;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // all pins disabled after reset: history only
    send_tick(32'h0000_0000);
    send_tick(32'hFFFF_FFFF);
    drain();

    // zero settle time, upper bits of the narrow registers dropped, spare index ignored
    write_reg(REG_SPARE, $urandom);
    set_config(32'hFFFF_FFFF, 32'hFFFF_0000, 32'h1234_0003);
    foreach (directed_lv[i]) send_tick(directed_lv[i]);
    drain();

    // disabling a pin mid-countdown cancels it
    set_config(32'h0000_FFFF, 32'd2, 32'd3);
    send_tick(32'hFFFF_FFFF);
    send_tick(32'hFFFF_FFFF);
    send_tick(32'hFFFF_FFFF);
    drain();
    write_reg(bdpc_pkg::REG_ENABLE_MASK, 32'hFFFF_FFFF);
    cfg_valid_i <= 1'b0;

    // random phases over several settings and idle patterns
    for (int ph = 0; ph < 7; ph++) begin
      drain();
      case (ph)
        0: set_config(32'hFFFF_FFFF, 32'd1, 32'd1);
        1: set_config($urandom, 32'd2, 32'd8);
        2: set_config($urandom | $urandom, 32'd4, 32'd20);
        3: set_config(32'hFFFF_FFFF, 32'd3, 32'd65535);
        4: set_config($urandom | $urandom, $urandom_range(6, 1), $urandom_range(30, 2));
        5: set_config(32'hFFFF_FFFF, 32'd2, 32'd6);
        default: set_config(32'hFFFF_FFFF, 32'd65535, 32'd1000);
      endcase
      if (ph < 2) begin
        send_idle_pct = 33;
        recv_idle_pct = 87;
      end else if (ph < 4) begin
        send_idle_pct = 87;
        recv_idle_pct = 33;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      repeat ((ph == 6) ? 30 : 75) send_tick(next_levels());
    end
    drain();

    if (sb.failures == 0 && sb.owed_events.size() == 0) begin
      $display("[button_debounce_press_classifier_unit] OK");
    end else begin
      $display("[button_debounce_press_classifier_unit] ERROR");
    end
    $finish;
  end

endmodule
